// ===== design/ffra_pkg.sv =====
// Package for the first-fit range allocator: operation and status codes, default sizes.
// Used by every module of the design except ffra_ram; depends on nothing.
`default_nettype none
package ffra_pkg;
  localparam int SLOTS_DEF     = 16;
  localparam int ADDR_BITS_DEF = 32;
  localparam int VAL_W         = 36;
  localparam int ALIGN_W       = 32;

  typedef enum logic [2:0] {
    FN_SET_USABLE   = 3'd0,
    FN_SET_UNUSABLE = 3'd1,
    FN_ALLOC        = 3'd2,
    FN_FREE         = 3'd3,
    FN_NEXT         = 3'd4,
    FN_COUNT        = 3'd5
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOFIT = 2'd1,
    ST_FULL  = 2'd2
  } stat_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_LOAD,
    CMD_MU_EVAL,
    CMD_MU_FILL,
    CMD_UN_EVAL,
    CMD_FIT_START,
    CMD_FIT_EVAL,
    CMD_CNT_EVAL
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t op;
  } ffra_cmd_t;

  typedef struct packed {
    logic       hit;
    logic       div_busy;
    logic       empty_range;
    logic [2:0] func;
  } ffra_stat_t;
endpackage
`default_nettype wire

// ===== design/first_fit_range_allocator.sv =====
// First-fit range allocator: a table of SLOTS half-open free ranges in RAM.
// One transaction at a time: the result follows a dispatch state plus the table walk,
// and the next input is taken in the cycle after the result is taken.
// The walk reads each slot and then evaluates it; allocate and next block also wait for the
// remainder unit on each used slot, and set unusable walks the table again for each split slot.
// Reset clears control state, then zeroes the table slot by slot with the input stalled.
`default_nettype none
module first_fit_range_allocator
  import ffra_pkg::*;
#(
  parameter int SLOTS     = SLOTS_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [2:0]        func,
  input  wire logic [31:0]       base_addr,
  input  wire logic [31:0]       limit_or_size,
  input  wire logic [31:0]       alignment,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [VAL_W-1:0]       value,
  output logic [1:0]             status
);
  ffra_cmd_t                cmd;
  ffra_stat_t               st;
  logic [$clog2(SLOTS)-1:0] idx;

  ffra_ctrl #(.SLOTS(SLOTS)) u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .st(st), .cmd(cmd),
    .idx(idx));

  ffra_dp #(.SLOTS(SLOTS), .ADDR_BITS(ADDR_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .idx(idx),
    .func(func), .base_addr(base_addr), .limit_or_size(limit_or_size),
    .alignment(alignment), .st(st), .value(value), .status(status));
endmodule
`default_nettype wire

// ===== design/ffra_ram.sv =====
// Generic single-port RAM with registered read.
// Depends on nothing.
`default_nettype none
module ffra_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ===== design/ffra_div.sv =====
// Bit-serial remainder unit: one quotient bit per cycle.
// Depends on ffra_pkg for widths.
`default_nettype none
module ffra_div
  import ffra_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [ADDR_BITS-1:0] dividend,
  input  wire logic [ALIGN_W-1:0]   divisor,
  output logic                      busy,
  output logic [ALIGN_W-1:0]        rem
);
  localparam int CW = $clog2(ADDR_BITS + 1);
  logic [ADDR_BITS-1:0] num;
  logic [ALIGN_W:0]     part;
  logic [CW-1:0]        cnt;
  logic [ALIGN_W:0]     shifted;

  assign shifted = {part[ALIGN_W-1:0], num[ADDR_BITS-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(ADDR_BITS);
      num  <= dividend;
      part <= '0;
    end else if (busy) begin
      num <= num << 1;
      if (shifted >= {1'b0, divisor}) begin
        part <= shifted - {1'b0, divisor};
      end else begin
        part <= shifted;
      end
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign rem = part[ALIGN_W-1:0];
endmodule
`default_nettype wire

// ===== design/ffra_dp.sv =====
// Datapath of the allocator: slot memories, operand registers, compare logic and results.
// Depends on ffra_pkg, ffra_ram and ffra_div.
`default_nettype none
module ffra_dp
  import ffra_pkg::*;
#(
  parameter int SLOTS     = SLOTS_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire ffra_cmd_t              cmd,
  input  wire logic [$clog2(SLOTS)-1:0] idx,
  input  wire logic [2:0]             func,
  input  wire logic [31:0]            base_addr,
  input  wire logic [31:0]            limit_or_size,
  input  wire logic [31:0]            alignment,
  output ffra_stat_t                  st,
  output logic [VAL_W-1:0]            value,
  output logic [1:0]                  status
);
  localparam int AW = ADDR_BITS;
  localparam int IW = $clog2(SLOTS);
  localparam int XW = ((AW > ALIGN_W) ? AW : ALIGN_W) + 2;
  localparam int SW = ((AW > VAL_W) ? AW : VAL_W) + 1;
  localparam logic [AW:0] AMAX = {1'b0, {AW{1'b1}}};
  localparam logic [SW-1:0] VSAT = SW'({VAL_W{1'b1}});

  logic [AW-1:0] s, e, us, ue, base, lim, rs_q, re_q, wdata_s, wdata_e;
  logic [ALIGN_W-1:0] align;
  logic [2:0]    fn;
  logic          we, used, div_start, div_busy;
  logic [AW-1:0] cand;
  logic [ALIGN_W-1:0] rem, pad;
  logic [XW-1:0] cand_up, fit_end;
  logic [SW-1:0] acc_sum;
  logic [VAL_W-1:0] acc, acc_next;
  logic          hit_c;

  ffra_ram #(.WIDTH(AW), .DEPTH(SLOTS)) u_start (
    .clk(clk), .we(we), .addr(idx), .wdata(wdata_s), .rdata(rs_q));
  ffra_ram #(.WIDTH(AW), .DEPTH(SLOTS)) u_end (
    .clk(clk), .we(we), .addr(idx), .wdata(wdata_e), .rdata(re_q));

  ffra_div #(.ADDR_BITS(AW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(cand),
    .divisor(align), .busy(div_busy), .rem(rem));

  assign used = rs_q != re_q;

  always_comb begin
    cand = rs_q;
    if (fn == FN_NEXT && base > rs_q) begin
      cand = base;
    end
  end

  assign div_start = cmd.op == CMD_FIT_START && used;
  assign pad       = (rem == '0) ? '0 : (align - rem);
  assign cand_up   = XW'(cand) + XW'(pad);
  assign fit_end   = cand_up + XW'(lim);

  always_comb begin
    we = 1'b0;
    wdata_s = rs_q;
    wdata_e = re_q;
    hit_c = 1'b0;
    case (cmd.op)
      CMD_CLEAR: begin
        we = 1'b1; wdata_s = '0; wdata_e = '0;
      end
      CMD_MU_EVAL: begin
        if (used) begin
          if (us >= rs_q && ue <= re_q) begin
            hit_c = 1'b1;
          end else if (us <= rs_q && ue >= re_q) begin
            hit_c = 1'b1; we = 1'b1; wdata_s = us; wdata_e = ue;
          end else if (us >= rs_q && us <= re_q) begin
            hit_c = 1'b1; we = 1'b1; wdata_e = ue;
          end else if (ue >= rs_q && ue <= re_q) begin
            hit_c = 1'b1; we = 1'b1; wdata_s = us;
          end
        end
      end
      CMD_MU_FILL: begin
        if (!used) begin
          hit_c = 1'b1; we = 1'b1; wdata_s = us; wdata_e = ue;
        end
      end
      CMD_UN_EVAL: begin
        if (used && !(e <= rs_q || s >= re_q)) begin
          we = 1'b1;
          if (s <= rs_q && e >= re_q) begin
            wdata_s = re_q;
          end else if (s > rs_q && e < re_q) begin
            wdata_e = s;
            hit_c   = 1'b1;
          end else if (s <= rs_q) begin
            wdata_s = e;
          end else begin
            wdata_e = s;
          end
        end
      end
      CMD_FIT_EVAL: begin
        if (used && fit_end <= XW'(re_q)) begin
          hit_c = 1'b1;
          if (fn == FN_ALLOC) begin
            we = 1'b1; wdata_s = fit_end[AW-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    st.hit         = hit_c;
    st.div_busy    = div_busy;
    st.empty_range = us >= ue;
    st.func        = fn;
  end

  assign acc_sum  = SW'(acc) + SW'(re_q - rs_q);
  assign acc_next = (acc_sum > VSAT) ? {VAL_W{1'b1}} : acc_sum[VAL_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      value  <= '0;
      status <= ST_OK;
    end else begin
      case (cmd.op)
        CMD_LOAD: begin
          fn    <= func;
          base  <= AW'(base_addr);
          lim   <= AW'(limit_or_size);
          align <= (alignment == '0) ? ALIGN_W'(1) : alignment;
          s     <= AW'(base_addr);
          e     <= AW'(limit_or_size);
          acc   <= '0;
          value  <= '0;
          status <= (func == FN_ALLOC || func == FN_NEXT) ? ST_NOFIT : ST_OK;
          us <= AW'(base_addr);
          if (func == FN_FREE) begin
            ue <= ({1'b0, AW'(base_addr)} + {1'b0, AW'(limit_or_size)} > AMAX)
                  ? AMAX[AW-1:0]
                  : AW'(base_addr) + AW'(limit_or_size);
          end else begin
            ue <= AW'(limit_or_size);
          end
        end
        CMD_MU_FILL: begin
          if (!hit_c && idx == IW'(SLOTS - 1)) begin
            status <= ST_FULL;
          end
        end
        CMD_UN_EVAL: begin
          if (hit_c) begin
            us <= e;
            ue <= re_q;
          end
        end
        CMD_FIT_EVAL: begin
          if (hit_c) begin
            value  <= VAL_W'(cand_up[AW-1:0]);
            status <= ST_OK;
          end
        end
        CMD_CNT_EVAL: begin
          if (used && re_q > rs_q) begin
            acc   <= acc_next;
            value <= acc_next;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== design/ffra_ctrl.sv =====
// Controller of the allocator: walks the slot table for each operation
// but empty ranges and unknown codes. Depends on ffra_pkg.
`default_nettype none
module ffra_ctrl
  import ffra_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  input  wire ffra_stat_t              st,
  output ffra_cmd_t                    cmd,
  output logic [$clog2(SLOTS)-1:0]     idx
);
  localparam int IW = $clog2(SLOTS);
  localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DISPATCH, S_CNT_RD, S_CNT, S_MU_RD, S_MU, S_MUF_RD, S_MUF,
    S_UN_RD, S_UN, S_SUB_RD, S_SUB, S_SUBF_RD, S_SUBF, S_RESUME, S_FIT_RD,
    S_FIT_START, S_FIT_WAIT, S_FIT, S_DONE
  } state_t;

  state_t        state;
  logic [IW-1:0] un_idx;

  assign in_stall  = state != S_IDLE;
  assign out_valid = state == S_DONE;

  always_comb begin
    cmd.op = CMD_NONE;
    case (state)
      S_CLEAR:       cmd.op = CMD_CLEAR;
      S_IDLE:        cmd.op = in_valid ? CMD_LOAD : CMD_NONE;
      S_MU, S_SUB:   cmd.op = CMD_MU_EVAL;
      S_MUF, S_SUBF: cmd.op = CMD_MU_FILL;
      S_UN:          cmd.op = CMD_UN_EVAL;
      S_FIT_START:   cmd.op = CMD_FIT_START;
      S_FIT:         cmd.op = CMD_FIT_EVAL;
      S_CNT:         cmd.op = CMD_CNT_EVAL;
      default:       cmd.op = CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLEAR;
      idx    <= '0;
      un_idx <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          if (idx == LAST) begin
            idx   <= '0;
            state <= S_IDLE;
          end else begin
            idx <= idx + IW'(1);
          end
        end
        S_IDLE: begin
          idx <= '0;
          if (in_valid) begin
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          idx <= '0;
          case (st.func)
            FN_SET_USABLE, FN_FREE:
              state <= st.empty_range ? S_DONE : S_MU_RD;
            FN_SET_UNUSABLE: state <= st.empty_range ? S_DONE : S_UN_RD;
            FN_ALLOC, FN_NEXT: state <= S_FIT_RD;
            FN_COUNT: state <= S_CNT_RD;
            default: state <= S_DONE;
          endcase
        end
        S_CNT_RD: begin
          state <= S_CNT;
        end
        S_CNT: begin
          if (idx == LAST) begin
            state <= S_DONE;
          end else begin
            idx   <= idx + IW'(1);
            state <= S_CNT_RD;
          end
        end
        S_MU_RD: begin
          state <= S_MU;
        end
        S_MU: begin
          if (st.hit) begin
            state <= S_DONE;
          end else if (idx == LAST) begin
            idx   <= '0;
            state <= S_MUF_RD;
          end else begin
            idx   <= idx + IW'(1);
            state <= S_MU_RD;
          end
        end
        S_MUF_RD: begin
          state <= S_MUF;
        end
        S_MUF: begin
          if (st.hit || idx == LAST) begin
            state <= S_DONE;
          end else begin
            idx   <= idx + IW'(1);
            state <= S_MUF_RD;
          end
        end
        S_UN_RD: begin
          state <= S_UN;
        end
        S_UN: begin
          if (st.hit) begin
            un_idx <= idx;
            idx    <= '0;
            state  <= S_SUB_RD;
          end else if (idx == LAST) begin
            state <= S_DONE;
          end else begin
            idx   <= idx + IW'(1);
            state <= S_UN_RD;
          end
        end
        S_SUB_RD: begin
          state <= S_SUB;
        end
        S_SUB: begin
          if (st.hit) begin
            state <= S_RESUME;
          end else if (idx == LAST) begin
            idx   <= '0;
            state <= S_SUBF_RD;
          end else begin
            idx   <= idx + IW'(1);
            state <= S_SUB_RD;
          end
        end
        S_SUBF_RD: begin
          state <= S_SUBF;
        end
        S_SUBF: begin
          if (st.hit || idx == LAST) begin
            state <= S_RESUME;
          end else begin
            idx   <= idx + IW'(1);
            state <= S_SUBF_RD;
          end
        end
        S_RESUME: begin
          if (un_idx == LAST) begin
            state <= S_DONE;
          end else begin
            idx   <= un_idx + IW'(1);
            state <= S_UN_RD;
          end
        end
        S_FIT_RD: begin
          state <= S_FIT_START;
        end
        S_FIT_START: begin
          state <= S_FIT_WAIT;
        end
        S_FIT_WAIT: begin
          if (!st.div_busy) begin
            state <= S_FIT;
          end
        end
        S_FIT: begin
          if (st.hit || idx == LAST) begin
            state <= S_DONE;
          end else begin
            idx   <= idx + IW'(1);
            state <= S_FIT_RD;
          end
        end
        S_DONE: begin
          if (!out_stall) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
